// ===== src/pcg32_bounded_random_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// pcg32 bounded random generator - assertion macros
// shared concurrent assertion forms on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef PCG32_BOUNDED_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define PCG32_BOUNDED_RANDOM_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define PCG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pcg32brg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg32brg_pkg
// types and constants of the pcg32 bounded random generator
// ----------------------------------------------------------------------------
package pcg32brg_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STATE_W   = 64;
    localparam int unsigned STREAM_W  = 63;
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [STATE_W-1:0]   LCG_MULT    = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0]   STATE_RESET = 64'd6364136223846793006;
    localparam logic [STATE_W-1:0]   INC_RESET   = 64'd1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'd31;

    localparam int unsigned XSH_SHIFT_A = 18;
    localparam int unsigned XSH_SHIFT_B = 27;
    localparam int unsigned ROT_POS     = 59;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 2'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RAW     = 2'd0,
        OP_BOUNDED = 2'd1,
        OP_RESEED  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_CLR,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FIN,
        ST_SEED_ADD,
        ST_BMUL,
        ST_BCHK,
        ST_DIV,
        ST_RESP
    } state_t;

endpackage

// ===== src/pcg32brg_if.sv =====
// ----------------------------------------------------------------------------
// pcg32brg_if
// valid/ready channels for draw requests and results
// ----------------------------------------------------------------------------
interface pcg32brg_req_if;
    logic                                valid;
    logic                                ready;
    logic [pcg32brg_pkg::OPCODE_W-1:0]   opcode;
    logic [pcg32brg_pkg::WORD_W-1:0]     bound;

    modport source (output valid, output opcode, output bound, input ready);
    modport sink   (input valid, input opcode, input bound, output ready);
endinterface

interface pcg32brg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pcg32brg_pkg::WORD_W-1:0]     random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== src/pcg32_bounded_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// pcg32_bounded_random_generator_core
// pcg32 xsh-rr generator with lemire bounded draws and reseeding
// ----------------------------------------------------------------------------
// usage:
// - req carries opcode and bound; each request gives exactly one result on rsp
// - opcode raw: one 32-bit draw
// - opcode bounded: draw mapped into 0..bound-1; when the low product word
//   falls below bound a serial remainder plus one recheck runs once and each
//   redraw repeats the lcg step; bound zero answers 0 without a draw
// - opcode reseed: seeding sequence from seed_value and stream_select,
//   answers 0; opcode 3 answers 0 and changes nothing
// - each lcg step is three 32x32 partial products through one shared
//   multiplier plus a final add
// - one request at a time: req.ready is high only while idle
// - the result sits in an output register; while rsp stalls the next request
//   is still taken, and it waits to deliver until the register frees
// - cfg_we/cfg_index/cfg_data write seed_value (0) and stream_select (1); user
//   writes only while idle, not enforced; a write does not reseed by itself
// - reset: seed, stream and control registers to 0, generator state as if
//   reseeded with seed and stream zero, no result pending
// ----------------------------------------------------------------------------
`include "pcg32_bounded_random_generator_core_defines.svh"

module pcg32_bounded_random_generator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    pcg32brg_req_if.sink                          req,
    pcg32brg_rsp_if.source                        rsp,
    input  logic                                  cfg_we,
    input  logic [pcg32brg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcg32brg_pkg::CFG_W-1:0]        cfg_data
);

    pcg32brg_pkg::state_t state_reg, state_next;

    logic [pcg32brg_pkg::STATE_W-1:0]   gen_reg, gen_next;
    logic [pcg32brg_pkg::STATE_W-1:0]   inc_reg, inc_next;
    logic [pcg32brg_pkg::STATE_W-1:0]   seed_reg;
    logic [pcg32brg_pkg::STREAM_W-1:0]  stream_reg;
    logic [pcg32brg_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                               thresh_valid_reg, thresh_valid_next;
    logic                               pass_reg, pass_next;
    logic                               out_valid_reg, out_valid_next;

    pcg32brg_pkg::op_t                  op_reg, op_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    bound_reg, bound_next;
    logic [pcg32brg_pkg::STATE_W-1:0]   prod_reg, prod_next;
    logic [pcg32brg_pkg::STATE_W-1:0]   acc_reg, acc_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    draw_reg, draw_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    rem_reg, rem_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    dvd_reg, dvd_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    res_reg, res_next;
    logic [pcg32brg_pkg::WORD_W-1:0]    out_val_reg, out_val_next;

    logic [pcg32brg_pkg::WORD_W-1:0]    mul_a, mul_b;
    logic [pcg32brg_pkg::STATE_W-1:0]   mul_p;
    logic [pcg32brg_pkg::WORD_W-1:0]    xsh_mixed, xsh_out;
    logic [4:0]                         xsh_rot;
    logic [pcg32brg_pkg::WORD_W:0]      rem_shift;
    logic                               rem_ge;
    logic                               accept;

    // xsh-rr output permutation of the old state
    always_comb
    begin
        xsh_mixed = 32'(((gen_reg >> pcg32brg_pkg::XSH_SHIFT_A) ^ gen_reg)
                         >> pcg32brg_pkg::XSH_SHIFT_B);
        xsh_rot   = gen_reg[pcg32brg_pkg::ROT_POS +: 5];
        xsh_out   = (xsh_mixed >> xsh_rot) | (xsh_mixed << 5'(5'd0 - xsh_rot));
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            pcg32brg_pkg::ST_MUL0:
            begin
                mul_a = gen_reg[31:0];
                mul_b = pcg32brg_pkg::LCG_MULT[31:0];
            end
            pcg32brg_pkg::ST_MUL1:
            begin
                mul_a = gen_reg[63:32];
                mul_b = pcg32brg_pkg::LCG_MULT[31:0];
            end
            pcg32brg_pkg::ST_MUL2:
            begin
                mul_a = gen_reg[31:0];
                mul_b = pcg32brg_pkg::LCG_MULT[63:32];
            end
            default:
            begin
                mul_a = draw_reg;
                mul_b = bound_reg;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // serial restoring remainder step
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[31]};
        rem_ge    = rem_shift >= {1'b0, bound_reg};
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == pcg32brg_pkg::ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.random_value = out_val_reg;

    always_comb
    begin
        state_next        = state_reg;
        gen_next          = gen_reg;
        inc_next          = inc_reg;
        div_cnt_next      = div_cnt_reg;
        thresh_valid_next = thresh_valid_reg;
        pass_next         = pass_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        op_next           = op_reg;
        bound_next        = bound_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        draw_next         = draw_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        res_next          = res_reg;
        out_val_next      = out_val_reg;

        case (state_reg)
            pcg32brg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next           = pcg32brg_pkg::op_t'(req.opcode);
                    bound_next        = req.bound;
                    thresh_valid_next = 1'b0;
                    pass_next         = 1'b0;
                    res_next          = '0;
                    case (pcg32brg_pkg::op_t'(req.opcode))
                        pcg32brg_pkg::OP_RAW:     state_next = pcg32brg_pkg::ST_MUL0;
                        pcg32brg_pkg::OP_BOUNDED:
                        begin
                            if (req.bound == '0)
                                state_next = pcg32brg_pkg::ST_RESP;
                            else
                                state_next = pcg32brg_pkg::ST_MUL0;
                        end
                        pcg32brg_pkg::OP_RESEED:  state_next = pcg32brg_pkg::ST_SEED_CLR;
                        default:                  state_next = pcg32brg_pkg::ST_RESP;
                    endcase
                end
            end
            pcg32brg_pkg::ST_SEED_CLR:
            begin
                gen_next   = '0;
                inc_next   = {stream_reg, 1'b1};
                state_next = pcg32brg_pkg::ST_MUL0;
            end
            pcg32brg_pkg::ST_MUL0:
            begin
                prod_next  = mul_p;
                draw_next  = xsh_out;
                state_next = pcg32brg_pkg::ST_MUL1;
            end
            pcg32brg_pkg::ST_MUL1:
            begin
                prod_next  = mul_p;
                acc_next   = prod_reg + (inc_reg | 64'd1);
                state_next = pcg32brg_pkg::ST_MUL2;
            end
            pcg32brg_pkg::ST_MUL2:
            begin
                prod_next  = mul_p;
                acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                state_next = pcg32brg_pkg::ST_FIN;
            end
            pcg32brg_pkg::ST_FIN:
            begin
                gen_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                case (op_reg)
                    pcg32brg_pkg::OP_RESEED:
                    begin
                        if (pass_reg)
                        begin
                            res_next   = '0;
                            state_next = pcg32brg_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = pcg32brg_pkg::ST_SEED_ADD;
                        end
                    end
                    pcg32brg_pkg::OP_BOUNDED: state_next = pcg32brg_pkg::ST_BMUL;
                    default:
                    begin
                        res_next   = draw_reg;
                        state_next = pcg32brg_pkg::ST_RESP;
                    end
                endcase
            end
            pcg32brg_pkg::ST_SEED_ADD:
            begin
                gen_next   = gen_reg + seed_reg;
                pass_next  = 1'b1;
                state_next = pcg32brg_pkg::ST_MUL0;
            end
            pcg32brg_pkg::ST_BMUL:
            begin
                prod_next  = mul_p;
                state_next = pcg32brg_pkg::ST_BCHK;
            end
            pcg32brg_pkg::ST_BCHK:
            begin
                if (prod_reg[31:0] >= bound_reg)
                begin
                    res_next   = prod_reg[63:32];
                    state_next = pcg32brg_pkg::ST_RESP;
                end
                else if (!thresh_valid_reg)
                begin
                    rem_next     = '0;
                    dvd_next     = 32'd0 - bound_reg;
                    div_cnt_next = '0;
                    state_next   = pcg32brg_pkg::ST_DIV;
                end
                else if (prod_reg[31:0] < rem_reg)
                begin
                    state_next = pcg32brg_pkg::ST_MUL0;
                end
                else
                begin
                    res_next   = prod_reg[63:32];
                    state_next = pcg32brg_pkg::ST_RESP;
                end
            end
            pcg32brg_pkg::ST_DIV:
            begin
                rem_next     = rem_ge ? 32'(rem_shift - {1'b0, bound_reg}) : 32'(rem_shift);
                dvd_next     = {dvd_reg[30:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == pcg32brg_pkg::DIV_LAST)
                begin
                    thresh_valid_next = 1'b1;
                    state_next        = pcg32brg_pkg::ST_BCHK;
                end
            end
            pcg32brg_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_reg;
                    state_next     = pcg32brg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcg32brg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pcg32brg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg          <= pcg32brg_pkg::STATE_RESET;
            inc_reg          <= pcg32brg_pkg::INC_RESET;
            seed_reg         <= '0;
            stream_reg       <= '0;
            div_cnt_reg      <= '0;
            thresh_valid_reg <= 1'b0;
            pass_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            gen_reg          <= gen_next;
            inc_reg          <= inc_next;
            div_cnt_reg      <= div_cnt_next;
            thresh_valid_reg <= thresh_valid_next;
            pass_reg         <= pass_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we && cfg_index == pcg32brg_pkg::CFG_SEED)
                seed_reg <= cfg_data;
            if (cfg_we && cfg_index == pcg32brg_pkg::CFG_STREAM)
                stream_reg <= cfg_data[pcg32brg_pkg::STREAM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        bound_reg   <= bound_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        draw_reg    <= draw_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
    end

    `PCG_ASSERT_IMPL(a_inc_odd, 1'b1, inc_reg[0], "stream increment lost its low bit")
    `PCG_ASSERT_IMPL(a_thresh_below_bound,
        state_reg == pcg32brg_pkg::ST_BCHK && thresh_valid_reg,
        rem_reg < bound_reg, "rejection threshold not below bound")
    `PCG_ASSERT_NEXT(a_div_done,
        state_reg == pcg32brg_pkg::ST_DIV && div_cnt_reg == pcg32brg_pkg::DIV_LAST,
        state_reg == pcg32brg_pkg::ST_BCHK && thresh_valid_reg,
        "remainder pass did not return to bound check")
    `PCG_ASSERT_IMPL(a_bounded_in_range,
        state_reg == pcg32brg_pkg::ST_RESP && op_reg == pcg32brg_pkg::OP_BOUNDED
            && bound_reg != '0,
        res_reg < bound_reg, "bounded result out of range")

endmodule
